// File: rtl/sbdc_pkg.sv
package sbdc_pkg;

    localparam int VALUE_BITS = 64;
    // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1); 30103 ~ 1e5*log10(2)
    localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = DIGITS * 4;
    localparam int BIT_W      = $clog2(VALUE_BITS + 1);
    localparam int CNT_W      = $clog2(DIGITS + 1);
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_shift;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic top_zero;
        logic cnt_one;
        logic negative;
    } t_status;

endpackage

// File: rtl/signed_binary_to_decimal_chars_core.sv
// Sequence: after the accepting edge all 64 shift-add-3 steps always run, then up to 18
//   leading zeros are dropped (units digit kept), then one character per cycle.
// Occupancy: a new transaction is accepted only while idle (busy low), i.e. after the
//   bit-serial double-dabble loop and the last decimal digit slot of the previous one.
// Reset: synchronous, active low; returns to idle and drops the strobe. The receiver
//   cannot stall: each character is on the ports for exactly one cycle.
module signed_binary_to_decimal_chars_core
    import sbdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [63:0]       i_value,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last
);

    // Controller sequences load -> convert -> skip zeros -> sign (negative only) -> digits;
    // datapath holds magnitude, BCD accumulator and the output register.
    t_cmd    cmd;
    t_status status;

    sbdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    sbdc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // an accepted transaction keeps the block busy through conversion
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // characters of one number come out back to back
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside character run");

    // nothing follows the final character until a new conversion
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("character after last");

    // only a minus sign or a digit is ever emitted
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == ASCII_MINUS) ||
                     ((o_char_code >= ASCII_ZERO) && (o_char_code <= ASCII_ZERO + 7'd9))))
        else $error("bad character code");

endmodule

// File: rtl/sbdc_dpath.sv
module sbdc_dpath
    import sbdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [63:0]       i_value,
    output t_status           o_status,
    output logic              o_valid,
    output logic [CHAR_W-1:0] o_char_code,
    output logic              o_last
);

    logic [VALUE_BITS-1:0] r_mag,  n_mag;
    logic                  r_neg,  n_neg;
    logic [BCD_W-1:0]      r_bcd,  n_bcd;
    logic [BCD_W-1:0]      adj;
    logic [BIT_W-1:0]      r_bit,  n_bit;
    logic [CNT_W-1:0]      r_cnt,  n_cnt;
    logic                  r_valid, n_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;
    logic [VALUE_BITS-1:0] raw;
    logic [3:0]            top;

    assign raw = i_value[VALUE_BITS-1:0];
    assign top = r_bcd[BCD_W-1 -: 4];

    // add-3 correction on every BCD digit ahead of the shift
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                      : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_bcd   = r_bcd;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        if (i_cmd.load) begin
            n_neg = raw[VALUE_BITS-1];
            n_mag = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
            n_bcd = '0;
            n_bit = BIT_W'(VALUE_BITS);
            n_cnt = CNT_W'(DIGITS);
        end
        if (i_cmd.conv_step) begin
            n_bcd = {adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_bit = r_bit - BIT_W'(1);
        end
        if (i_cmd.skip_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
            n_cnt = r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = ASCII_MINUS;
            n_last  = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_valid = 1'b1;
            n_char  = ASCII_ZERO + {3'b000, top};
            n_last  = (r_cnt == CNT_W'(1));
            n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
            n_cnt   = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_status.conv_last = (r_bit == BIT_W'(1));
    assign o_status.top_zero  = (top == 4'd0);
    assign o_status.cnt_one   = (r_cnt == CNT_W'(1));
    assign o_status.negative  = r_neg;

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

// File: rtl/sbdc_ctrl.sv
module sbdc_ctrl
    import sbdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_last) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, always keep the units digit
                if (i_status.top_zero && !i_status.cnt_one) begin
                    o_cmd.skip_shift = 1'b1;
                end else if (i_status.negative) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.cnt_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule
